FILE: hw/rtl/pspc_pkg.sv
package pspc_pkg;

    // input beat: one section byte or a table clear
    typedef struct packed {
        logic        operation;
        logic [7:0]  section_byte;
        logic        first_byte;
    } item_t;

    // result beat: a newly stored or dropped pmt pid
    typedef struct packed {
        logic [12:0] new_pid;
        logic [4:0]  slot_index;
        logic        dropped_full;
    } result_t;

    // operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // pid limits
    localparam logic [12:0] PID_MIN      = 13'h0010;
    localparam logic [12:0] PID_NULL     = 13'h1fff;
    localparam logic [12:0] PID_RSVD_MAX = 13'h0012;

    // section layout
    localparam logic [11:0] POS_LEN_HI    = 12'd1;
    localparam logic [11:0] POS_LEN_LO    = 12'd2;
    localparam logic [11:0] POS_FIRST_ENT = 12'd8;
    localparam logic [11:0] LEN_OVERHEAD  = 12'd9;
    localparam logic [1:0]  ENT_PID_HI    = 2'd2;
    localparam logic [1:0]  ENT_PID_LO    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic search_init;
        logic search_read;
        logic search_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_search;
        logic search_done;
        logic match;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/pspc_ram.sv
module pspc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/pspc_ctrl.sv
module pspc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pspc_pkg::status_t status,
    output pspc_pkg::cmd_t    cmd
);

    import pspc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.need_search)
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.search_read = 1'b1;
                    state_next      = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.match)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    state_next      = ST_SEARCH;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pspc_dp.sv
module pspc_dp #(
    parameter int TABLE_DEPTH = 32,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pspc_pkg::item_t   item,
    input  pspc_pkg::cmd_t    cmd,
    output pspc_pkg::status_t status,
    output logic              result_valid,
    input  logic              result_ready,
    output pspc_pkg::result_t result
);

    import pspc_pkg::*;

    logic [11:0]   pos_reg, pos_next;
    logic [11:0]   len_reg, len_next;
    logic [9:0]    entries_reg, entries_next;
    logic [4:0]    pid_hi_reg, pid_hi_next;
    logic          halted_reg, halted_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [12:0]   pid_reg;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg;

    logic [11:0]   full_len;
    logic [11:0]   len_minus;
    logic [12:0]   pid_in;
    logic          pid_bad;
    logic [9:0]    entries_dec;
    logic          is_pid_byte;
    logic          table_full;
    logic [12:0]   rd_data;

    assign full_len    = {len_reg[11:8], item.section_byte};
    assign len_minus   = full_len - LEN_OVERHEAD;
    assign pid_in      = {pid_hi_reg, item.section_byte};
    assign pid_bad     = (pid_in < PID_MIN) || (pid_in == PID_NULL);
    assign entries_dec = entries_reg - 10'd1;
    assign table_full  = (count_reg == CW'(TABLE_DEPTH));

    // a byte that closes a program entry
    assign is_pid_byte = (item.operation == OP_BYTE) && !item.first_byte && !halted_reg
                         && (pos_reg >= POS_FIRST_ENT) && (pos_reg[1:0] == ENT_PID_LO);

    assign status.need_search = is_pid_byte && !pid_bad && (pid_in > PID_RSVD_MAX);
    assign status.search_done = (idx_reg == count_reg);
    assign status.match       = (rd_data == pid_reg);
    assign status.out_free    = !res_valid_reg || result_ready;

    // section parse state
    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        entries_next = entries_reg;
        pid_hi_next  = pid_hi_reg;
        halted_next  = halted_reg;
        if (cmd.load_item && item.operation == OP_BYTE)
        begin
            if (item.first_byte)
            begin
                pos_next     = POS_LEN_HI;
                len_next     = '0;
                entries_next = '0;
                pid_hi_next  = '0;
                halted_next  = (item.section_byte != 8'd0);
            end
            else if (!halted_reg)
            begin
                pos_next = pos_reg + 12'd1;
                if (pos_reg == POS_LEN_HI)
                begin
                    len_next = {item.section_byte[3:0], 8'd0};
                end
                else if (pos_reg == POS_LEN_LO)
                begin
                    len_next = full_len;
                    if (full_len >= LEN_OVERHEAD)
                    begin
                        entries_next = len_minus[11:2];
                    end
                    else
                    begin
                        entries_next = '0;
                    end
                    if (full_len < LEN_OVERHEAD || len_minus[11:2] == 10'd0)
                    begin
                        halted_next = 1'b1;
                    end
                end
                else if (pos_reg >= POS_FIRST_ENT && pos_reg[1:0] == ENT_PID_HI)
                begin
                    pid_hi_next = item.section_byte[4:0];
                end
                else if (is_pid_byte)
                begin
                    if (pid_bad)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        entries_next = entries_dec;
                        if (entries_dec == 10'd0)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // table fill count and search index
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.load_item && item.operation == OP_CLEAR)
        begin
            count_next = '0;
        end
        if (cmd.emit && !table_full)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.search_init)
        begin
            idx_next = '0;
        end
        else if (cmd.search_step)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            entries_reg   <= '0;
            pid_hi_reg    <= '0;
            halted_reg    <= 1'b1;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            entries_reg   <= entries_next;
            pid_hi_reg    <= pid_hi_next;
            halted_reg    <= halted_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            pid_reg <= pid_in;
        end
        if (cmd.emit)
        begin
            res_reg.new_pid <= pid_reg;
            if (table_full)
            begin
                res_reg.slot_index   <= 5'd0;
                res_reg.dropped_full <= 1'b1;
            end
            else
            begin
                res_reg.slot_index   <= 5'(count_reg);
                res_reg.dropped_full <= 1'b0;
            end
        end
    end

    // pid table
    pspc_ram #(
        .WIDTH (13),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.emit && !table_full),
        .waddr (count_reg[AW-1:0]),
        .wdata (pid_reg),
        .re    (cmd.search_read),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

FILE: hw/rtl/pat_section_pmt_pid_collector.sv
// a byte that starts no table search is accepted with no hold; a program entry with a
// new pid (above 0x12) holds the input while each stored pid is read and compared, and
// while a waiting result beat stalls, then it is emitted and the result is valid the next cycle
// a known pid found in slot k holds the input while slots 0 to k are read and compared
// throughput: one byte per cycle unless a one-read-port table walk holds the input
// reset: parse idle until a first byte, table empty (fill count zero), no clearing pass
module pat_section_pmt_pid_collector #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pspc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output pspc_pkg::result_t result
);

    import pspc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    pspc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // parse state, table and result register
    pspc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hw/rtl/pspc_checker.sv
module pspc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input pspc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input pspc_pkg::result_t result
);

    import pspc_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a dropped pid never carries a slot
    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped_full |-> result.slot_index == 5'd0)
        else $error("dropped pid with nonzero slot");

    // only pids above the reserved range and below the null pid are reported
    a_pid_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.new_pid > PID_RSVD_MAX) && (result.new_pid != PID_NULL))
        else $error("reported pid out of range");

    // a new result appears only after the input side was held off
    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared without a table search");

endmodule

bind pat_section_pmt_pid_collector pspc_checker u_pspc_checker (.*);

FILE: bench/pspc_pid_report_check.sv
`timescale 1ns / 1ps

// watches both channels, predicts pid reports from the accepted bytes and
// compares every accepted result beat with the oldest pending report
module pspc_pid_report_check #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  pspc_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  pspc_pkg::result_t result,
    output int                mismatches,
    output int                reports_open
);

    import pspc_pkg::*;

    // shadow of the section parser
    logic [11:0] byte_idx;
    logic [11:0] sect_len;
    logic [9:0]  entries_todo;
    logic [4:0]  pid_upper;
    logic        parse_off;

    // shadow of the pid table
    logic [12:0] pid_store [TABLE_DEPTH];
    int          fill;

    result_t     reports_due [$];
    int          errs;

    // advance the shadow by one beat; returns 1 when a pid report follows
    function automatic bit collect_pid(input item_t it, output result_t rep);
        logic [11:0] at;
        logic [1:0]  phase;
        logic [12:0] pid;
        rep = '0;
        if (it.operation == OP_CLEAR)
        begin
            fill = 0;
            return 1'b0;
        end
        if (it.first_byte)
        begin
            byte_idx     = 12'd1;
            sect_len     = '0;
            entries_todo = '0;
            pid_upper    = '0;
            parse_off    = (it.section_byte != 8'h00);
            return 1'b0;
        end
        if (parse_off)
            return 1'b0;
        at       = byte_idx;
        byte_idx = byte_idx + 12'd1;
        if (at == POS_LEN_HI)
        begin
            sect_len = {it.section_byte[3:0], 8'h00};
            return 1'b0;
        end
        if (at == POS_LEN_LO)
        begin
            sect_len     = {sect_len[11:8], it.section_byte};
            entries_todo = (sect_len >= LEN_OVERHEAD) ?
                           10'((sect_len - LEN_OVERHEAD) >> 2) : 10'd0;
            if (entries_todo == 10'd0)
                parse_off = 1'b1;
            return 1'b0;
        end
        if (at < POS_FIRST_ENT)
            return 1'b0;
        phase = 2'(at - POS_FIRST_ENT);
        if (phase == ENT_PID_HI)
        begin
            pid_upper = it.section_byte[4:0];
            return 1'b0;
        end
        if (phase != ENT_PID_LO)
            return 1'b0;
        pid = {pid_upper, it.section_byte};
        // out-of-range pid stops the rest of the section
        if (pid < PID_MIN || pid >= PID_NULL)
        begin
            parse_off = 1'b1;
            return 1'b0;
        end
        entries_todo = entries_todo - 10'd1;
        if (entries_todo == 10'd0)
            parse_off = 1'b1;
        if (pid <= PID_RSVD_MAX)
            return 1'b0;
        for (int i = 0; i < fill; i++)
            if (pid_store[i] == pid)
                return 1'b0;
        rep.new_pid = pid;
        if (fill < TABLE_DEPTH)
        begin
            pid_store[fill]  = pid;
            rep.slot_index   = 5'(fill);
            rep.dropped_full = 1'b0;
            fill++;
        end
        else
        begin
            rep.slot_index   = '0;
            rep.dropped_full = 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t due;
        result_t got;
        if (!rst_n)
        begin
            byte_idx     = '0;
            sect_len     = '0;
            entries_todo = '0;
            pid_upper    = '0;
            parse_off    = 1'b1;
            fill         = 0;
            errs         = 0;
            reports_due.delete();
            mismatches   <= 0;
            reports_open <= 0;
        end
        else
        begin
            // input beat first, a result may leave on the same edge
            if (item_valid && item_ready)
            begin
                if (collect_pid(item, due))
                    reports_due = {reports_due, due};
            end
            if (result_valid && result_ready)
            begin
                got = result;
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, %s %0h %0d %0b",
                             $time, "got pid/slot/drop", got.new_pid, got.slot_index,
                             got.dropped_full);
                    errs++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (got.new_pid !== due.new_pid)
                    begin
                        $display("%0t: new_pid mismatch, expected %0h, got %0h",
                                 $time, due.new_pid, got.new_pid);
                        errs++;
                    end
                    if (got.slot_index !== due.slot_index)
                    begin
                        $display("%0t: slot_index mismatch, expected %0d, got %0d",
                                 $time, due.slot_index, got.slot_index);
                        errs++;
                    end
                    if (got.dropped_full !== due.dropped_full)
                    begin
                        $display("%0t: dropped_full mismatch, expected %0b, got %0b",
                                 $time, due.dropped_full, got.dropped_full);
                        errs++;
                    end
                end
            end
            mismatches   <= errs;
            reports_open <= reports_due.size();
        end
    end

endmodule

FILE: bench/tb_pat_section_pmt_pid_collector.sv
`timescale 1ns / 1ps

module tb_pat_section_pmt_pid_collector;

    import pspc_pkg::*;

    localparam int DEPTH      = 32;
    localparam int LIVE_BEATS = 1480;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item_beat    = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result_beat;

    int          mismatches;
    int          reports_open;
    int          live_beats = 0;
    bit          quiet      = 1'b0;
    logic [12:0] seen_pids [$];

    pat_section_pmt_pid_collector #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat)
    );

    pspc_pid_report_check #(
        .TABLE_DEPTH (DEPTH)
    ) u_pid_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat),
        .mismatches   (mismatches),
        .reports_open (reports_open)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // alternate stretches with and without idling
    initial
    begin
        forever
        begin
            repeat ($urandom_range(150, 400)) @(posedge clk);
            quiet <= ~quiet;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pid mix: fresh, repeated, reserved, out of range, anything
    function automatic logic [12:0] pick_pid();
        int          r;
        logic [12:0] pid;
        r = $urandom_range(0, 99);
        if (r < 20 && seen_pids.size() > 0)
            return seen_pids[$urandom_range(0, seen_pids.size() - 1)];
        if (r < 25)
            return 13'($urandom_range(16, 18));
        if (r < 29)
            return ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 15)) : PID_NULL;
        if (r < 36)
            return 13'($urandom);
        pid = 13'($urandom_range(19, 8190));
        seen_pids = {seen_pids, pid};
        if (seen_pids.size() > 40)
            void'(seen_pids.pop_front());
        return pid;
    endfunction

    // one input beat, held until accepted, then an optional gap
    task automatic send_beat(input logic op, input logic [7:0] b, input logic fb,
                             input bit live);
        item_t it;
        int    gap;
        it.operation    = op;
        it.section_byte = b;
        it.first_byte   = fb;
        item_valid <= 1'b1;
        item_beat  <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (live)
            live_beats++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // section with a zero table id byte and random content; broken ones stop early
    task automatic send_random_section();
        int          shape;
        int          n_ent;
        int          cut;
        int          sent;
        logic [11:0] len;
        logic [12:0] pid;
        logic [7:0]  ent [4];
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            n_ent = 0;
            len   = 12'($urandom_range(0, 12));
        end
        else if (shape < 13)
        begin
            n_ent = $urandom_range(16, 40);
            len   = 12'(9 + 4 * n_ent + $urandom_range(0, 3));
        end
        else
        begin
            n_ent = $urandom_range(1, 8);
            len   = 12'(9 + 4 * n_ent + $urandom_range(0, 3));
        end
        cut = -1;
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(0, 4 * n_ent);
            if ($urandom_range(0, 1) == 0)
                len = 12'($urandom);
        end
        send_beat(OP_BYTE, 8'h00, 1'b1, 1'b1);
        send_beat(OP_BYTE, {4'($urandom), len[11:8]}, 1'b0, 1'b1);
        send_beat(OP_BYTE, len[7:0], 1'b0, 1'b1);
        repeat (5) send_beat(OP_BYTE, 8'($urandom), 1'b0, 1'b1);
        sent = 0;
        for (int k = 0; k < n_ent; k++)
        begin
            pid    = pick_pid();
            ent[0] = 8'($urandom);
            ent[1] = 8'($urandom);
            ent[2] = {3'($urandom), pid[12:8]};
            ent[3] = pid[7:0];
            for (int j = 0; j < 4; j++)
            begin
                if (sent == cut)
                    return;
                send_beat(OP_BYTE, ent[j], 1'b0, 1'b1);
                sent++;
            end
        end
        // crc bytes, sometimes truncated
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4)
            send_beat(OP_BYTE, 8'($urandom), 1'b0, 1'b0);
    endtask

    // result side stalls
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear with don't-care fields, nonzero table id byte
        send_beat(OP_CLEAR, 8'hff, 1'b1, 1'b1);
        send_beat(OP_BYTE, 8'h01, 1'b1, 1'b1);
        send_beat(OP_BYTE, 8'hff, 1'b0, 1'b1);
        // length field 25: four entries
        send_beat(OP_BYTE, 8'h00, 1'b1, 1'b1);
        send_beat(OP_BYTE, 8'hb0, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h19, 1'b0, 1'b1);
        repeat (5) send_beat(OP_BYTE, 8'h00, 1'b0, 1'b1);
        // highest storable pid
        send_beat(OP_BYTE, 8'h00, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h01, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'hff, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'hfe, 1'b0, 1'b1);
        // reserved pid, accepted but not stored
        send_beat(OP_BYTE, 8'h00, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h02, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'he0, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h12, 1'b0, 1'b1);
        // lowest storable pid
        send_beat(OP_BYTE, 8'h00, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h03, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'he0, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'h13, 1'b0, 1'b1);
        // known pid again
        send_beat(OP_BYTE, 8'hff, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'hff, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'hff, 1'b0, 1'b1);
        send_beat(OP_BYTE, 8'hfe, 1'b0, 1'b1);

        // random: mostly well-formed sections, some clears and noise
        while (live_beats < LIVE_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 1'b1);
            else if (pick < 12)
            begin
                repeat ($urandom_range(2, 8))
                    send_beat(OP_BYTE, 8'($urandom), ($urandom_range(0, 5) == 0), 1'b0);
            end
            else if (pick < 18)
            begin
                send_beat(OP_BYTE, 8'($urandom_range(1, 255)), 1'b1, 1'b1);
                repeat ($urandom_range(1, 6))
                    send_beat(OP_BYTE, 8'($urandom), 1'b0, 1'b0);
            end
            else
                send_random_section();
        end
        item_valid <= 1'b0;

        // drain, then watch for stray beats
        repeat (2) @(posedge clk);
        while (reports_open != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && reports_open == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: pat_section_pmt_pid_collector.f
hw/rtl/pspc_pkg.sv
hw/rtl/pspc_ram.sv
hw/rtl/pspc_ctrl.sv
hw/rtl/pspc_dp.sv
hw/rtl/pat_section_pmt_pid_collector.sv
hw/rtl/pspc_checker.sv
bench/pspc_pid_report_check.sv
bench/tb_pat_section_pmt_pid_collector.sv
